>>> design/fic_pkg.sv
package fic_pkg;

   // Operation selector codes.
   typedef enum logic [1:0] {
      FUNC_F2U = 2'd0,
      FUNC_F2S = 2'd1,
      FUNC_U2F = 2'd2,
      FUNC_S2F = 2'd3
   } func_type;

   localparam int FRAC_BITS = 23;
   localparam logic [7:0] EXP_BIAS = 8'd127;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   // Registered operand of one conversion.
   typedef struct packed {
      func_type    func;
      logic [31:0] float_bits;
      logic [63:0] int_value;
   } operand_type;

endpackage

>>> design/fic_core.sv
module fic_core (
   input  fic_pkg::operand_type op,
   output logic [63:0]          result
);
   import fic_pkg::*;

   logic        sign;
   logic [7:0]  expo;
   logic [23:0] mant;
   logic [7:0]  e_unb;
   logic [63:0] mag;
   logic [63:0] f2u;
   logic [63:0] f2s_mag;
   logic [63:0] f2s;
   logic        neg_int;
   logic [63:0] absv;
   logic [5:0]  p;
   logic        nz;
   logic [63:0] norm;
   logic [23:0] m24;
   logic        guard;
   logic        sticky;
   logic        rnd_up;
   logic [31:0] fbits;

   // Float to integer: shift the mantissa by the unbiased exponent.
   always_comb begin
      sign  = op.float_bits[31];
      expo  = op.float_bits[30:23];
      mant  = {1'b1, op.float_bits[22:0]};
      e_unb = expo - EXP_BIAS;
      if (e_unb < 8'(FRAC_BITS)) begin
         mag = {40'd0, mant} >> (5'(FRAC_BITS) - e_unb[4:0]);
      end else begin
         mag = {40'd0, mant} << (e_unb[5:0] - 6'(FRAC_BITS));
      end
      if (sign || expo < EXP_BIAS) begin
         f2u = '0;
      end else if (expo >= EXP_BIAS + 8'd64) begin
         f2u = ALL_ONES;
      end else begin
         f2u = mag;
      end
      if (expo < EXP_BIAS) begin
         f2s_mag = '0;
      end else if (expo >= EXP_BIAS + 8'd63) begin
         f2s_mag = S64_MAX;
      end else begin
         f2s_mag = mag;
      end
      f2s = sign ? (64'd0 - f2s_mag) : f2s_mag;
   end

   // Integer to float: find the leading one, normalize, round to nearest even.
   always_comb begin
      neg_int = (op.func == FUNC_S2F) && op.int_value[63];
      absv    = neg_int ? (64'd0 - op.int_value) : op.int_value;
      nz      = |absv;
      p       = '0;
      for (int i = 0; i < 64; i++) begin
         if (absv[i]) begin
            p = 6'(i);
         end
      end
      norm   = absv << (6'd63 - p);
      m24    = norm[63:40];
      guard  = norm[39];
      sticky = |norm[38:0];
      rnd_up = guard && (sticky || m24[0]);
      fbits  = ({1'b0, 8'(EXP_BIAS - 8'd1 + {2'b00, p}), 23'd0})
               + {8'd0, m24} + {31'd0, rnd_up};
      if (!nz) begin
         fbits = '0;
      end else if (neg_int) begin
         fbits[31] = 1'b1;
      end
   end

   // Result selection.
   always_comb begin
      unique case (op.func)
         FUNC_F2U: result = f2u;
         FUNC_F2S: result = f2s;
         FUNC_U2F: result = {32'd0, fbits};
         FUNC_S2F: result = {32'd0, fbits};
         default:  result = '0;
      endcase
   end

endmodule

>>> design/float_int64_converter.sv
// Channel   Ports                                       Direction
// request   start, busy, req_func,                      in (busy out)
//           req_float_bits, req_int_value
// response  rsp_valid, rsp_result_bits                  out
// One item is accepted in every cycle; busy is always low.
// The transfer loads the operand register, and the result register is then
// loaded from it through the conversion logic; the result reaches the ports
// from the result register. Reset clears the valid flags only.
// The receiver cannot stall, so results are never held back.
module float_int64_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_float_bits,
   input  logic [63:0] req_int_value,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_bits
);
   import fic_pkg::*;

   operand_type op_ff;
   logic        op_valid_ff;
   logic        rsp_valid_ff;
   logic [63:0] result_ff;
   logic [63:0] result_in;

   assign busy = 1'b0;

   // Operand register.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff <= 1'b0;
      end else begin
         op_valid_ff <= start;
      end
      op_ff <= '{func: func_type'(req_func), float_bits: req_float_bits,
                 int_value: req_int_value};
   end

   fic_core u_core (
      .op     (op_ff),
      .result (result_in)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= op_valid_ff;
      end
      result_ff <= result_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_bits = result_ff;

endmodule
